@@ hw/rtl/lbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and constants
// Item structs, opcodes, controller states and datapath commands for the
// skinning core.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int BoneSlots    = 31;
	localparam int IdentityBone = BoneSlots - 1;
	localparam int TableDepth   = IdentityBone * 12;
	localparam int AddrW        = $clog2(TableDepth);

	localparam logic signed [31:0] SatMax = 32'sh7fffffff;
	localparam logic signed [31:0] SatMin = 32'sh80000000;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SKIN  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [8:0]         table_address;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
		logic [19:0]        bone_indices;
		logic [16:0]        weight_a;
		logic [16:0]        weight_b;
		logic [16:0]        weight_c;
		logic [16:0]        weight_d;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MAC,
		ST_WEIGHT,
		ST_ACCUM,
		ST_BOX,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;      // capture input item
		logic       tbl_write; // write table word
		logic       clear_box;
		logic       rd_en;     // read table word
		logic [3:0] word;      // word index within bone
		logic       mac;       // accumulate product or translation of previous read
		logic       init_acc;  // clear accumulator
		logic       weight;    // weight the bone result
		logic       accum;     // add term into position
		logic       box;       // update bounding box
		logic [1:0] infl;      // current influence
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] opcode;
		logic       first_ident; // bone a is identity
		logic [2:0] count;       // clamped influence count
		logic [3:0] wnz;         // nonzero weights
		logic       ident;       // current influence bone is identity
	} status_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647) return SatMax;
		if (v < -50'sd2147483648) return SatMin;
		return v[31:0];
	endfunction

endpackage

@@ hw/rtl/lbs_ram.sv @@
// ----------------------------------------------------------------------------
// lbs_ram: generic single port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lbs_ram #(
	parameter int Width = 32,
	parameter int Depth = 360
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

@@ hw/rtl/lbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbs_ctrl: skinning sequencer
// Steps through table reads, weighting and accumulation per influence.
// ----------------------------------------------------------------------------
module lbs_ctrl import lbs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t st,
	output cmd_t    cmd
);
	state_t state_q, state_d;
	logic [3:0] word_q, word_d;
	logic [1:0] infl_q, infl_d;
	logic       rd_q;  // a read was issued last cycle
	logic       ovalid_q, ovalid_d;
	logic       go;
	logic       next_ok;

	assign in_stall  = (state_q != ST_IDLE) || (ovalid_q && out_stall);
	assign go        = in_valid && !in_stall;
	assign out_valid = ovalid_q;
	// further influence is taken while in range and weight nonzero
	assign next_ok   = ({1'b0, infl_q} + 3'd1 < st.count) && st.wnz[infl_q + 2'd1];

	always_comb begin
		state_d  = state_q;
		word_d   = word_q;
		infl_d   = infl_q;
		ovalid_d = ovalid_q && out_stall;
		case (state_q)
			ST_IDLE: begin
				if (go && in_valid) begin
					state_d = ST_FETCH;
					word_d  = 4'd0;
					infl_d  = 2'd0;
				end
			end
			ST_FETCH: begin
				if (st.opcode != OP_SKIN) begin
					state_d = ST_IDLE;
				end else if (st.first_ident) begin
					state_d = ST_BOX;
				end else if (st.ident) begin
					state_d = ST_WEIGHT;
				end else begin
					state_d = ST_MAC;
					word_d  = 4'd0;
				end
			end
			ST_MAC: begin
				if (word_q == 4'd12) begin
					state_d = ST_WEIGHT;
				end else begin
					word_d = word_q + 4'd1;
				end
			end
			ST_WEIGHT: state_d = ST_ACCUM;
			ST_ACCUM: begin
				if (next_ok) begin
					infl_d  = infl_q + 2'd1;
					state_d = ST_FETCH;
				end else begin
					state_d = ST_BOX;
				end
			end
			ST_BOX: state_d = ST_OUT;
			ST_OUT: begin
				if (!(ovalid_q && out_stall)) begin
					ovalid_d = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = go;
		cmd.word      = word_q;
		cmd.infl      = infl_q;
		cmd.tbl_write = (state_q == ST_FETCH) && (st.opcode == OP_WRITE);
		cmd.clear_box = (state_q == ST_FETCH) && (st.opcode == OP_CLEAR);
		cmd.init_acc  = (state_q == ST_FETCH);
		cmd.rd_en     = (state_q == ST_MAC) && (word_q < 4'd12);
		cmd.mac       = (state_q == ST_MAC) && rd_q;
		cmd.weight    = (state_q == ST_WEIGHT);
		cmd.accum     = (state_q == ST_ACCUM);
		cmd.box       = (state_q == ST_BOX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			word_q   <= '0;
			infl_q   <= '0;
			rd_q     <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			word_q   <= word_d;
			infl_q   <= infl_d;
			rd_q     <= cmd.rd_en;
			ovalid_q <= ovalid_d;
		end
	end
endmodule

@@ hw/rtl/lbs_dp.sv @@
// ----------------------------------------------------------------------------
// lbs_dp: skinning datapath
// Table memory, one multiply per cycle, weighting, saturating sums and box.
// ----------------------------------------------------------------------------
module lbs_dp import lbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  logic [2:0] max_influence,
	input  cmd_t      cmd,
	output status_t   st,
	output out_item_t out_item
);
	in_item_t           item_q;
	logic signed [31:0] rdata;
	logic signed [49:0] acc_q [3];
	logic signed [31:0] p_q [3];
	logic signed [31:0] pos_q [3];
	logic signed [31:0] bmin_q [3];
	logic signed [31:0] bmax_q [3];
	logic [3:0]         wprev_q;
	logic [4:0]         idx [4];
	logic [16:0]        w [4];
	logic [4:0]         bone;
	logic [AddrW-1:0]   raddr;
	logic [AddrW-1:0]   addr;
	logic signed [31:0] src [3];
	logic signed [63:0] prod;
	logic [1:0]         wi, wj;
	logic signed [31:0] wsel;
	logic signed [63:0] wfull [3];
	logic signed [49:0] wprod [3];
	logic signed [49:0] wsum [3];

	assign src[0] = item_q.value_x;
	assign src[1] = item_q.value_y;
	assign src[2] = item_q.value_z;
	for (genvar k = 0; k < 4; k++) begin : g_inf
		assign idx[k] = item_q.bone_indices[5*k +: 5];
	end
	assign w[0] = item_q.weight_a;
	assign w[1] = item_q.weight_b;
	assign w[2] = item_q.weight_c;
	assign w[3] = item_q.weight_d;
	assign bone = idx[cmd.infl];

	assign raddr = AddrW'({4'd0, bone} * 9'd12 + {5'd0, cmd.word});
	assign addr  = cmd.tbl_write ? item_q.table_address[AddrW-1:0] : raddr;

	lbs_ram #(.Width(32), .Depth(TableDepth)) u_ram (
		.clk  (clk),
		.we   (cmd.tbl_write && ({23'd0, item_q.table_address} < TableDepth)),
		.re   (cmd.rd_en),
		.addr (addr),
		.wdata(item_q.value_x),
		.rdata(rdata)
	);

	// word just read (word-1): row j = w/3, column i = w%3, or translation
	always_ff @(posedge clk) begin
		wprev_q <= cmd.word;
	end
	always_comb begin
		wi = 2'd0;
		wj = 2'd0;
		case (wprev_q)
			4'd0: begin wj = 2'd0; wi = 2'd0; end
			4'd1: begin wj = 2'd0; wi = 2'd1; end
			4'd2: begin wj = 2'd0; wi = 2'd2; end
			4'd3: begin wj = 2'd1; wi = 2'd0; end
			4'd4: begin wj = 2'd1; wi = 2'd1; end
			4'd5: begin wj = 2'd1; wi = 2'd2; end
			4'd6: begin wj = 2'd2; wi = 2'd0; end
			4'd7: begin wj = 2'd2; wi = 2'd1; end
			4'd8: begin wj = 2'd2; wi = 2'd2; end
			4'd9: wi = 2'd0;
			4'd10: wi = 2'd1;
			4'd11: wi = 2'd2;
			default: ;
		endcase
	end
	assign prod = rdata * src[wj];
	assign wsel = $signed({15'd0, w[cmd.infl]});

	// 32 x 32 weighting multiply per axis, floor shift, saturating add
	for (genvar i = 0; i < 3; i++) begin : g_ax
		assign wfull[i] = p_q[i] * wsel;
		assign wprod[i] = 50'(wfull[i] >>> 16);
		assign wsum[i]  = 50'(pos_q[i]) + 50'(sat32(wprod[i]));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		for (int i = 0; i < 3; i++) begin
			if (cmd.init_acc) begin
				acc_q[i] <= '0;
			end else if (cmd.mac && (2'(i) == wi)) begin
				acc_q[i] <= (wprev_q >= 4'd9) ? acc_q[i] + 50'(rdata)
					: acc_q[i] + 50'(prod >>> 16);
			end
			if (cmd.weight) begin
				p_q[i] <= (bone >= 5'(IdentityBone)) ? src[i] : sat32(acc_q[i]);
			end
			if (cmd.accum) begin
				pos_q[i] <= (cmd.infl == 2'd0) ? sat32(wprod[i]) : sat32(wsum[i]);
			end
			if (cmd.init_acc && st.first_ident && item_q.opcode == OP_SKIN) begin
				pos_q[i] <= src[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				bmin_q[i] <= SatMax;
				bmax_q[i] <= SatMin;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (cmd.clear_box) begin
					bmin_q[i] <= SatMax;
					bmax_q[i] <= SatMin;
				end else if (cmd.box) begin
					if (pos_q[i] < bmin_q[i]) bmin_q[i] <= pos_q[i];
					if (pos_q[i] > bmax_q[i]) bmax_q[i] <= pos_q[i];
				end
			end
		end
	end

	assign st.opcode      = item_q.opcode;
	assign st.first_ident = idx[0] >= 5'(IdentityBone);
	assign st.ident       = bone >= 5'(IdentityBone);
	assign st.count       = (max_influence == 3'd0) ? 3'd1
		: (max_influence > 3'd4) ? 3'd4 : max_influence;
	for (genvar k = 0; k < 4; k++) begin : g_wnz
		assign st.wnz[k] = w[k] != 17'd0;
	end

	assign out_item.pos_x     = pos_q[0];
	assign out_item.pos_y     = pos_q[1];
	assign out_item.pos_z     = pos_q[2];
	assign out_item.box_min_x = bmin_q[0];
	assign out_item.box_min_y = bmin_q[1];
	assign out_item.box_min_z = bmin_q[2];
	assign out_item.box_max_x = bmax_q[0];
	assign out_item.box_max_y = bmax_q[1];
	assign out_item.box_max_z = bmax_q[2];
endmodule

@@ hw/rtl/linear_blend_vertex_skinning_core.sv @@
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_core: four bone linear blend skinning
// Q16.16 skinning with a 360 word bone table and a running bounding box.
// ----------------------------------------------------------------------------
// Write, clear and unused opcodes return to idle from the fetch state. A skin item
// with an identity first bone skips the table; else each table bone is read word
// by word over the single table port (one word a cycle).
// One item at a time. The result sits in the output register until taken.
// Reset: box min to most positive, max to most negative, max_influence to 4;
// the bone table is undefined until written.
module linear_blend_vertex_skinning_core import lbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic [2:0] cfg_wdata
);
	logic [2:0] max_influence_q;
	cmd_t       cmd;
	status_t    st;

	// influence count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_influence_q <= 3'd4;
		end else if (cfg_we) begin
			max_influence_q <= cfg_wdata;
		end
	end

	lbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.st       (st),
		.cmd      (cmd)
	);

	lbs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_item      (in_item),
		.max_influence(max_influence_q),
		.cmd          (cmd),
		.st           (st),
		.out_item     (out_item)
	);

	// a held result must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");
	// no read and write of the table at once
	a_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && cmd.tbl_write))
		else $error("table port conflict");
	// box updates only while busy
	a_box: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.box |-> in_stall)
		else $error("box update while idle");
endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: skinning core self-checking bench
// Drives bone table writes, box clears and skin items through the valid/stall
// handshake, predicts each skinned vertex and bounding box in a local model,
// and compares every result field against it under several idle patterns.
// ----------------------------------------------------------------------------
module testbench;
	import lbs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles   = 100;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;
	logic      cfg_we;
	logic [2:0] cfg_wdata;

	linear_blend_vertex_skinning_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// local copy of the block state
	logic signed [31:0] bones [TableDepth];
	logic signed [31:0] lo_box [3];
	logic signed [31:0] hi_box [3];
	logic [2:0]         infl_reg;

	out_item_t vertex_q [$];
	int        mismatches;
	int        send_idle_pct, stall_pct;
	bit        hold_off;
	int        quiet_cycles;

	function automatic logic signed [63:0] sat_q(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// >>> on a signed value floors toward minus infinity
	function automatic logic signed [63:0] floor16(input logic signed [63:0] v);
		return v >>> 16;
	endfunction

	function automatic void weighted_bone(input int b, input logic signed [63:0] src [3],
			input logic [16:0] w, output logic signed [63:0] term [3]);
		logic signed [63:0] acc, p;
		for (int i = 0; i < 3; i++) begin
			if (b >= IdentityBone) begin
				p = src[i];
			end else begin
				acc = 64'(bones[b*12 + 9 + i]);
				for (int j = 0; j < 3; j++)
					acc += floor16(64'(bones[b*12 + j*3 + i]) * src[j]);
				p = sat_q(acc);
			end
			term[i] = sat_q(floor16(p * $signed({47'd0, w})));
		end
	endfunction

	// update the model for one accepted item; queue the skinned vertex
	function automatic void predict_item(input in_item_t it);
		logic signed [63:0] src [3], pos [3], term [3];
		logic [16:0] w [4];
		int idx [4];
		int cnt;
		out_item_t r;
		case (opcode_t'(it.opcode))
			OP_WRITE: if (it.table_address < TableDepth) begin
				bones[it.table_address] = it.value_x;
			end
			OP_CLEAR: for (int i = 0; i < 3; i++) begin
				lo_box[i] = SatMax;
				hi_box[i] = SatMin;
			end
			OP_SKIN: begin
				src[0] = it.value_x; src[1] = it.value_y; src[2] = it.value_z;
				w[0] = it.weight_a; w[1] = it.weight_b; w[2] = it.weight_c; w[3] = it.weight_d;
				for (int k = 0; k < 4; k++) idx[k] = it.bone_indices[5*k +: 5];
				cnt = (infl_reg < 1) ? 1 : (infl_reg > 4) ? 4 : infl_reg;
				if (idx[0] >= IdentityBone) begin
					pos = src;
				end else begin
					weighted_bone(idx[0], src, w[0], pos);
					for (int k = 1; k < cnt; k++) begin
						if (w[k] == 0) break;
						weighted_bone(idx[k], src, w[k], term);
						for (int i = 0; i < 3; i++) pos[i] = sat_q(pos[i] + term[i]);
					end
				end
				for (int i = 0; i < 3; i++) begin
					if (pos[i] < lo_box[i]) lo_box[i] = pos[i][31:0];
					if (pos[i] > hi_box[i]) hi_box[i] = pos[i][31:0];
				end
				r.pos_x = pos[0][31:0]; r.pos_y = pos[1][31:0]; r.pos_z = pos[2][31:0];
				r.box_min_x = lo_box[0]; r.box_min_y = lo_box[1]; r.box_min_z = lo_box[2];
				r.box_max_x = hi_box[0]; r.box_max_y = hi_box[1]; r.box_max_z = hi_box[2];
				vertex_q.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// checks a result against the oldest prediction; a result with no prediction
	// waiting is reported as unexpected
	task automatic check_vertex(input out_item_t got);
		out_item_t exp_v;
		if (vertex_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %p", got);
			return;
		end
		exp_v = vertex_q.pop_front();
		if (got !== exp_v) begin
			mismatches++;
			if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_v, got);
		end
	endtask

	// output side: random stalls, with an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall) check_vertex(out_item);
			out_stall <= hold_off || ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog: cycles with no accepted item on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// send one item; idle gaps first, then hold until accepted
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_item(it);
	endtask

	task automatic go_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_influence(input logic [2:0] v);
		go_quiet();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		infl_reg  = v;
	endtask

	function automatic in_item_t make_write(input int addr, input logic [31:0] v);
		in_item_t it;
		it = '0;
		it.opcode = OP_WRITE;
		it.table_address = 9'(addr);
		it.value_x = v;
		return it;
	endfunction

	function automatic in_item_t make_skin(input logic [31:0] x, y, z,
			input logic [19:0] bi, input logic [16:0] wa, wb, wc, wd);
		in_item_t it;
		it = '0;
		it.opcode = OP_SKIN;
		it.value_x = x; it.value_y = y; it.value_z = z;
		it.bone_indices = bi;
		it.weight_a = wa; it.weight_b = wb; it.weight_c = wc; it.weight_d = wd;
		return it;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(65536) - 32768;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [16:0] rand_weight();
		case ($urandom_range(7))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'h1ffff;
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	// bone index only among loaded bones (slots 0 to 7) or identity
	function automatic logic [4:0] rand_bone();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 5'd30;
		if (r == 1) return 5'd31;
		return 5'($urandom_range(7));
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		int r;
		it = '0;
		r = $urandom_range(99);
		if (r < 70) begin
			it = make_skin(rand_word(), rand_word(), rand_word(),
				{rand_bone(), rand_bone(), rand_bone(), rand_bone()},
				rand_weight(), rand_weight(), rand_weight(), rand_weight());
			if ($urandom_range(3) == 0) it.weight_a = 17'($urandom);
		end else if (r < 88) begin
			it = make_write($urandom_range(8*12 - 1), rand_word());
		end else if (r < 93) begin
			it = make_write($urandom_range(511, TableDepth), $urandom);
		end else if (r < 97) begin
			it.opcode = OP_CLEAR;
		end else begin
			it.opcode = OP_NONE;
		end
		// bits unused by the opcode still toggle
		if (it.opcode != OP_SKIN) begin
			it.value_y = $urandom; it.value_z = $urandom;
			it.bone_indices = 20'($urandom);
			it.weight_a = 17'($urandom); it.weight_b = 17'($urandom);
		end
		if (it.opcode != OP_WRITE) it.table_address = 9'($urandom);
		return it;
	endfunction

	// directed rows: item plus, where obvious, the typed-in result
	typedef struct {
		in_item_t  it;
		bit        has_exp;
		out_item_t exp_v;
	} row_t;

	row_t rows [$];

	initial begin
		row_t rw;
		out_item_t e;
		int phase_pct [4][2] = '{'{0, 0}, '{80, 0}, '{0, 80}, '{27, 27}};
		logic [2:0] infl_set [5] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		quiet_cycles = 0;
		infl_reg = 3'd4;
		for (int i = 0; i < TableDepth; i++) begin
			bones[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			lo_box[i] = SatMax;
			hi_box[i] = SatMin;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity first bone right after reset: copy of the source, box = point
		e = '{32'h7fffffff, 32'h80000000, 32'h0,
			32'h7fffffff, 32'h80000000, 32'h0,
			32'h7fffffff, 32'h80000000, 32'h0};
		rw.it = make_skin(32'h7fffffff, 32'h80000000, 0, 20'd30, 0, 0, 0, 0);
		rw.has_exp = 1; rw.exp_v = e; rows.push_back(rw);
		rw.has_exp = 0;
		// load the eight working bones fully, slot 29 at the table end too
		for (int b = 0; b < 8; b++)
			for (int wd = 0; wd < 12; wd++) begin
				rw.it = make_write(b*12 + wd, (wd % 4 == 0) ? 32'h10000 : rand_word());
				rows.push_back(rw);
			end
		for (int wd = 0; wd < 12; wd++) begin
			rw.it = make_write(29*12 + wd, rand_word());
			rows.push_back(rw);
		end
		// out-of-range writes are ignored
		rw.it = make_write(TableDepth, 32'hdeadbeef); rows.push_back(rw);
		rw.it = make_write(511, 32'hffffffff); rows.push_back(rw);
		rw.it = '0; rw.it.opcode = OP_CLEAR; rows.push_back(rw);
		rw.it = '1; rw.it.opcode = OP_NONE; rows.push_back(rw);
		// zero first weight, full chain, chain stop, identity further bone,
		// oversize weights, saturation, last table slot
		rw.it = make_skin(32'h10000, 32'h20000, 32'hfffe0000, {5'd3, 5'd2, 5'd1, 5'd0},
			0, 17'h8000, 17'h8000, 17'h8000); rows.push_back(rw);
		rw.it = make_skin(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			{5'd29, 5'd4, 5'd30, 5'd5}, 17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff);
		rows.push_back(rw);
		rw.it = make_skin(32'h80000000, 32'h80000000, 32'h80000000,
			{5'd1, 5'd31, 5'd2, 5'd6}, 17'h10000, 0, 17'h10000, 17'h10000);
		rows.push_back(rw);
		rw.it = make_skin(32'h12345, 32'hfedcba98, 32'h1, {5'd7, 5'd6, 5'd5, 5'd4},
			17'h10000, 17'h1, 17'h10000, 17'h0); rows.push_back(rw);

		foreach (rows[i]) begin
			if (rows[i].has_exp && rows[i].exp_v != '0) begin
				// typed-in row checked against the local model as well
				send_item(rows[i].it);
				if (vertex_q[$] !== rows[i].exp_v) begin
					mismatches++;
					$display("directed row %0d: model disagrees with typed result", i);
				end
			end else begin
				send_item(rows[i].it);
			end
		end

		// random part over idle phases and influence settings
		for (int ph = 0; ph < 5; ph++) begin
			set_influence(infl_set[ph]);
			send_idle_pct = phase_pct[ph % 4][0];
			stall_pct = phase_pct[ph % 4][1];
			for (int n = 0; n < 80; n++) begin
				if (ph == 1 && n == 20) begin
					// long receiver hold-off while items keep coming
					send_idle_pct = 0;
					hold_off <= 1'b1;
					fork
						begin
							repeat (300) @(posedge clk);
							hold_off <= 1'b0;
						end
					join_none
				end
				send_item(rand_item());
			end
		end

		in_valid <= 1'b0;
		stall_pct = 10;
		@(posedge clk);
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/lbs_pkg.sv
hw/rtl/lbs_ram.sv
hw/rtl/lbs_ctrl.sv
hw/rtl/lbs_dp.sv
hw/rtl/linear_blend_vertex_skinning_core.sv
verif/testbench.sv
